// ===== rtl/lpnal_pkg.sv =====
`timescale 1ns / 1ps

package lpnal_pkg;

    localparam int UNIT_LEN_BITS_DEF = 24;
    localparam int QUEUE_DEPTH_DEF   = 4;
    localparam int UNIT_BYTES_W      = 24;
    localparam int LEN_ACC_W         = 32;
    localparam int LEN_SIZE_W        = 3;

    localparam logic [LEN_SIZE_W-1:0] LEN_SIZE_RESET = 3'd4;
    localparam logic [LEN_SIZE_W-1:0] LEN_SIZE_MIN   = 3'd1;
    localparam logic [LEN_SIZE_W-1:0] LEN_SIZE_MAX   = 3'd4;

    localparam logic [7:0] SC_BYTE_ZERO = 8'h00;
    localparam logic [7:0] SC_BYTE_ONE  = 8'h01;

    typedef enum logic {
        KIND_PAYLOAD,
        KIND_START
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       nal_end;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/lpnal_front.sv =====
`timescale 1ns / 1ps

module lpnal_front #(
    parameter int UNIT_LEN_BITS = lpnal_pkg::UNIT_LEN_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_first_of_unit,
    input  logic [lpnal_pkg::UNIT_BYTES_W-1:0]  i_unit_bytes,
    input  logic                                i_cfg_we,
    input  logic [lpnal_pkg::LEN_SIZE_W-1:0]    i_cfg_data,
    output logic                                o_wr_en,
    output lpnal_pkg::t_entry                   o_wr_entry
);

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_PAYLOAD,
        PH_DROP
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [2:0]                          r_prefix_count, n_prefix_count;
    logic [lpnal_pkg::LEN_ACC_W-1:0]     r_len_acc, n_len_acc;
    logic [UNIT_LEN_BITS-1:0]            r_payload_left, n_payload_left;
    logic [UNIT_LEN_BITS-1:0]            r_unit_left, n_unit_left;
    logic [lpnal_pkg::LEN_SIZE_W-1:0]    r_length_size;
    logic [lpnal_pkg::LEN_SIZE_W-1:0]    eff_size;
    logic [UNIT_LEN_BITS-1:0]            unit_old;
    logic [lpnal_pkg::LEN_ACC_W-1:0]     len_val;

    always_comb begin
        priority if (r_length_size < lpnal_pkg::LEN_SIZE_MIN) begin
            eff_size = lpnal_pkg::LEN_SIZE_MIN;
        end else if (r_length_size > lpnal_pkg::LEN_SIZE_MAX) begin
            eff_size = lpnal_pkg::LEN_SIZE_MAX;
        end else begin
            eff_size = r_length_size;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_prefix_count = r_prefix_count;
        n_len_acc      = r_len_acc;
        n_payload_left = r_payload_left;
        n_unit_left    = r_unit_left;
        unit_old       = '0;
        len_val        = '0;
        o_wr_en        = 1'b0;
        o_wr_entry.kind    = lpnal_pkg::KIND_PAYLOAD;
        o_wr_entry.data    = i_data_byte;
        o_wr_entry.nal_end = 1'b0;
        if (i_accept) begin
            if (i_first_of_unit) begin
                n_phase        = PH_PREFIX;
                n_prefix_count = '0;
                n_len_acc      = '0;
                n_payload_left = '0;
                n_unit_left    = UNIT_LEN_BITS'(i_unit_bytes);
            end
            if (n_unit_left != '0) begin
                unit_old    = n_unit_left;
                n_unit_left = n_unit_left - 1'b1;
                unique case (n_phase)
                    PH_PAYLOAD: begin
                        if (n_payload_left != '0) begin
                            n_payload_left = n_payload_left - 1'b1;
                        end
                        o_wr_en            = 1'b1;
                        o_wr_entry.nal_end = (n_payload_left == '0);
                        if (n_payload_left == '0) begin
                            n_phase = PH_PREFIX;
                        end
                    end
                    PH_PREFIX: begin
                        if (n_prefix_count == '0 && unit_old < UNIT_LEN_BITS'(eff_size)) begin
                            n_phase = PH_DROP;
                        end else begin
                            n_len_acc      = {n_len_acc[lpnal_pkg::LEN_ACC_W-9:0], i_data_byte};
                            n_prefix_count = n_prefix_count + 3'd1;
                            if (n_prefix_count >= eff_size) begin
                                len_val        = n_len_acc;
                                n_prefix_count = '0;
                                n_len_acc      = '0;
                                if (len_val > lpnal_pkg::LEN_ACC_W'(n_unit_left)) begin
                                    n_phase = PH_DROP;
                                end else if (len_val != '0) begin
                                    n_payload_left  = len_val[UNIT_LEN_BITS-1:0];
                                    n_phase         = PH_PAYLOAD;
                                    o_wr_en         = 1'b1;
                                    o_wr_entry.kind = lpnal_pkg::KIND_START;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_PREFIX;
            r_prefix_count <= '0;
            r_len_acc      <= '0;
            r_payload_left <= '0;
            r_unit_left    <= '0;
            r_length_size  <= lpnal_pkg::LEN_SIZE_RESET;
        end else begin
            r_phase        <= n_phase;
            r_prefix_count <= n_prefix_count;
            r_len_acc      <= n_len_acc;
            r_payload_left <= n_payload_left;
            r_unit_left    <= n_unit_left;
            if (i_cfg_we) begin
                r_length_size <= i_cfg_data;
            end
        end
    end

endmodule

// ===== rtl/lpnal_queue.sv =====
`timescale 1ns / 1ps

module lpnal_queue #(
    parameter int DEPTH = lpnal_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  lpnal_pkg::t_entry    i_wr_entry,
    input  logic                 i_rd_en,
    output lpnal_pkg::t_entry    o_rd_entry,
    output lpnal_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lpnal_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_wr, do_rd;

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign o_rd_entry     = r_mem[r_rd_ptr];
    assign do_wr          = i_wr_en && !o_status.full;
    assign do_rd          = i_rd_en && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/lpnal_back.sv =====
`timescale 1ns / 1ps

module lpnal_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lpnal_pkg::t_q_status i_q_status,
    input  lpnal_pkg::t_entry    i_rd_entry,
    output logic                 o_rd_en,
    input  logic                 pop,
    output logic                 empty,
    output logic [7:0]           o_out_byte,
    output logic                 o_nal_start,
    output logic                 o_nal_end,
    output logic                 o_last_of_run
);

    logic       r_valid, n_valid;
    logic [1:0] r_sc_left, n_sc_left;
    logic [7:0] r_byte, n_byte;
    logic       r_start, n_start;
    logic       r_end, n_end;
    logic       r_last, n_last;
    logic       load;

    assign load = !r_valid || pop;

    always_comb begin
        n_valid   = r_valid;
        n_sc_left = r_sc_left;
        n_byte    = r_byte;
        n_start   = r_start;
        n_end     = r_end;
        n_last    = r_last;
        o_rd_en   = 1'b0;
        if (load) begin
            if (r_sc_left != 2'd0) begin
                // rest of the start code
                n_valid   = 1'b1;
                n_byte    = (r_sc_left == 2'd1) ? lpnal_pkg::SC_BYTE_ONE
                                                : lpnal_pkg::SC_BYTE_ZERO;
                n_start   = 1'b0;
                n_end     = 1'b0;
                n_last    = (r_sc_left == 2'd1);
                n_sc_left = r_sc_left - 2'd1;
            end else if (!i_q_status.empty) begin
                o_rd_en = 1'b1;
                n_valid = 1'b1;
                unique case (i_rd_entry.kind)
                    lpnal_pkg::KIND_START: begin
                        n_byte    = lpnal_pkg::SC_BYTE_ZERO;
                        n_start   = 1'b1;
                        n_end     = 1'b0;
                        n_last    = 1'b0;
                        n_sc_left = 2'd2;
                    end
                    default: begin
                        n_byte  = i_rd_entry.data;
                        n_start = 1'b0;
                        n_end   = i_rd_entry.nal_end;
                        n_last  = 1'b1;
                    end
                endcase
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_sc_left <= 2'd0;
        end else begin
            r_valid   <= n_valid;
            r_sc_left <= n_sc_left;
        end
        r_byte  <= n_byte;
        r_start <= n_start;
        r_end   <= n_end;
        r_last  <= n_last;
    end

    assign empty         = !r_valid;
    assign o_out_byte    = r_byte;
    assign o_nal_start   = r_start;
    assign o_nal_end     = r_end;
    assign o_last_of_run = r_last;

endmodule

// ===== rtl/length_prefixed_nal_to_start_code.sv =====
// result path: each byte's results pass the queue and then the output register, which holds while pop is low
// throughput: one input byte per cycle while full is low; each nal start code gives three output bytes,
// absorbed by a four-entry queue between parser and output stage before full rises
// reset: synchronous active-low; clears parser state and queue, length_size returns to 4
`timescale 1ns / 1ps

module length_prefixed_nal_to_start_code #(
    parameter int UNIT_LEN_BITS = lpnal_pkg::UNIT_LEN_BITS_DEF,
    parameter int QUEUE_DEPTH   = lpnal_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_first_of_unit,
    input  logic [lpnal_pkg::UNIT_BYTES_W-1:0] i_unit_bytes,
    input  logic                               pop,
    output logic                               empty,
    output logic [7:0]                         o_out_byte,
    output logic                               o_nal_start,
    output logic                               o_nal_end,
    output logic                               o_last_of_run,
    input  logic                               i_cfg_we,
    input  logic [lpnal_pkg::LEN_SIZE_W-1:0]   i_cfg_data
);

    lpnal_pkg::t_entry    wr_entry, rd_entry;
    lpnal_pkg::t_q_status q_status;
    logic                 wr_en, rd_en, accept;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    lpnal_front #(
        .UNIT_LEN_BITS(UNIT_LEN_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_first_of_unit(i_first_of_unit),
        .i_unit_bytes   (i_unit_bytes),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_wr_en        (wr_en),
        .o_wr_entry     (wr_entry)
    );

    lpnal_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_entry(wr_entry),
        .i_rd_en   (rd_en),
        .o_rd_entry(rd_entry),
        .o_status  (q_status)
    );

    lpnal_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (q_status),
        .i_rd_entry   (rd_entry),
        .o_rd_en      (rd_en),
        .pop          (pop),
        .empty        (empty),
        .o_out_byte   (o_out_byte),
        .o_nal_start  (o_nal_start),
        .o_nal_end    (o_nal_end),
        .o_last_of_run(o_last_of_run)
    );

`ifndef SYNTH
    a_start_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_nal_start) |->
            (o_out_byte == lpnal_pkg::SC_BYTE_ZERO && !o_nal_end && !o_last_of_run))
        else $error("start code first byte malformed");

    a_start_second_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_nal_start) |=>
            (!empty && !o_nal_start && o_out_byte == lpnal_pkg::SC_BYTE_ZERO
             && !o_last_of_run))
        else $error("start code second byte missing");

    a_start_third_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_nal_start && !o_last_of_run) |=>
            (!empty && o_out_byte == lpnal_pkg::SC_BYTE_ONE && o_last_of_run
             && !o_nal_end))
        else $error("start code third byte missing");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en |-> !q_status.full))
        else $error("queue written while full");
`endif

endmodule

// ===== tb/sv/tb_length_prefixed_nal_to_start_code.sv =====
`timescale 1ns / 1ps

module tb_length_prefixed_nal_to_start_code;

    localparam int UNIT_BYTES_W = lpnal_pkg::UNIT_BYTES_W;
    localparam int LEN_SIZE_W   = lpnal_pkg::LEN_SIZE_W;
    localparam int LEN_ACC_W    = lpnal_pkg::LEN_ACC_W;

    localparam logic [LEN_SIZE_W-1:0] LEN_SIZE_RESET = lpnal_pkg::LEN_SIZE_RESET;
    localparam logic [LEN_SIZE_W-1:0] LEN_SIZE_MIN   = lpnal_pkg::LEN_SIZE_MIN;
    localparam logic [LEN_SIZE_W-1:0] LEN_SIZE_MAX   = lpnal_pkg::LEN_SIZE_MAX;
    localparam logic [7:0]            SC_BYTE_ZERO   = lpnal_pkg::SC_BYTE_ZERO;
    localparam logic [7:0]            SC_BYTE_ONE    = lpnal_pkg::SC_BYTE_ONE;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_PAYLOAD,
        PH_DROP
    } t_parse_ph;

    typedef enum logic {
        ROW_BYTE,
        ROW_SIZE
    } t_row_kind;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       nal_start;
        logic       nal_end;
        logic       last_of_run;
    } t_frame_res;

    typedef struct {
        t_row_kind               kind;
        logic [7:0]              data;
        logic                    first;
        logic [UNIT_BYTES_W-1:0] ub;
        logic [LEN_SIZE_W-1:0]   size;
        int                      exp_n;
        logic                    exp_end;
    } t_stim_row;

    // length size per random stretch, entry 0 first
    localparam logic [8:0][LEN_SIZE_W-1:0] SIZE_PLAN =
        {3'd4, 3'd6, 3'd5, 3'd7, 3'd0, 3'd3, 3'd2, 3'd4, 3'd1};
    localparam int ITEMS_PER_STRETCH = 40;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_push   = 1'b0;
    logic                    in_full;
    logic [7:0]              in_data   = '0;
    logic                    in_first  = 1'b0;
    logic [UNIT_BYTES_W-1:0] in_ub     = '0;
    logic                    out_pop   = 1'b0;
    logic                    out_empty;
    logic [7:0]              out_byte;
    logic                    out_start;
    logic                    out_end;
    logic                    out_last;
    logic                    cfg_we    = 1'b0;
    logic [LEN_SIZE_W-1:0]   cfg_data  = '0;

    // framing predictor state
    logic [LEN_SIZE_W-1:0]   len_size_p  = LEN_SIZE_RESET;
    t_parse_ph               parse_ph    = PH_LEN;
    logic [2:0]              pfx_cnt     = '0;
    logic [LEN_ACC_W-1:0]    len_acc     = '0;
    logic [LEN_ACC_W-1:0]    pay_left    = '0;
    logic [UNIT_BYTES_W-1:0] unit_left_p = '0;
    t_frame_res              pred_res [3];

    t_frame_res expected_frames[$];
    t_stim_row  rows[$];

    int send_idle      = 14;
    int recv_idle      = 53;
    int items_taken    = 0;
    int frames_checked = 0;
    int size_writes    = 0;
    int errors         = 0;

    length_prefixed_nal_to_start_code u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .push            (in_push),
        .full            (in_full),
        .i_data_byte     (in_data),
        .i_first_of_unit (in_first),
        .i_unit_bytes    (in_ub),
        .pop             (out_pop),
        .empty           (out_empty),
        .o_out_byte      (out_byte),
        .o_nal_start     (out_start),
        .o_nal_end       (out_end),
        .o_last_of_run   (out_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [LEN_SIZE_W-1:0] eff_len_size();
        if (len_size_p < LEN_SIZE_MIN) return LEN_SIZE_MIN;
        if (len_size_p > LEN_SIZE_MAX) return LEN_SIZE_MAX;
        return len_size_p;
    endfunction

    function automatic t_frame_res sc_entry(int k);
        case (k)
            0:       return '{SC_BYTE_ZERO, 1'b1, 1'b0, 1'b0};
            1:       return '{SC_BYTE_ZERO, 1'b0, 1'b0, 1'b0};
            default: return '{SC_BYTE_ONE, 1'b0, 1'b0, 1'b1};
        endcase
    endfunction

    task automatic add_frame(input t_frame_res f);
        expected_frames.insert(expected_frames.size(), f);
    endtask

    task automatic add_row(input t_stim_row r);
        rows.insert(rows.size(), r);
    endtask

    // advances the framing state by one byte, fills pred_res, returns result count
    function automatic int predict_frame(logic [7:0] b, logic first,
                                         logic [UNIT_BYTES_W-1:0] ub);
        logic [LEN_SIZE_W-1:0] s;
        logic [LEN_ACC_W-1:0]  len;
        s = eff_len_size();
        if (first) begin
            parse_ph    = PH_LEN;
            pfx_cnt     = '0;
            len_acc     = '0;
            pay_left    = '0;
            unit_left_p = ub;
        end
        if (unit_left_p == '0) return 0;
        unit_left_p = unit_left_p - 1'b1;
        if (parse_ph == PH_PAYLOAD) begin
            if (pay_left != '0) pay_left = pay_left - 1'b1;
            pred_res[0] = '{b, 1'b0, pay_left == '0, 1'b1};
            if (pay_left == '0) parse_ph = PH_LEN;
            return 1;
        end
        if (parse_ph == PH_DROP) return 0;
        // short tail: not enough bytes left for a whole prefix
        if (pfx_cnt == '0 && {8'd0, unit_left_p} + 32'd1 < 32'(s)) begin
            parse_ph = PH_DROP;
            return 0;
        end
        len_acc = {len_acc[LEN_ACC_W-9:0], b};
        pfx_cnt = pfx_cnt + 3'd1;
        if (pfx_cnt < s) return 0;
        len     = len_acc;
        pfx_cnt = '0;
        len_acc = '0;
        if (len > {8'd0, unit_left_p}) begin
            parse_ph = PH_DROP;
            return 0;
        end
        if (len == '0) return 0;
        pay_left = len;
        parse_ph = PH_PAYLOAD;
        for (int k = 0; k < 3; k++) pred_res[k] = sc_entry(k);
        return 3;
    endfunction

    function automatic t_stim_row byte_row(logic [7:0] d, logic first,
                                           logic [UNIT_BYTES_W-1:0] ub,
                                           int exp_n, logic exp_end);
        t_stim_row r;
        r.kind    = ROW_BYTE;
        r.data    = d;
        r.first   = first;
        r.ub      = ub;
        r.size    = '0;
        r.exp_n   = exp_n;
        r.exp_end = exp_end;
        return r;
    endfunction

    function automatic t_stim_row size_row(logic [LEN_SIZE_W-1:0] v);
        t_stim_row r;
        r         = byte_row(8'h00, 1'b0, '0, 0, 1'b0);
        r.kind    = ROW_SIZE;
        r.size    = v;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic first,
                             input logic [UNIT_BYTES_W-1:0] ub,
                             input int typed_n, input logic typed_end);
        int n;
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle) begin
            in_push <= 1'b0;
            @(negedge clk);
        end
        in_push  <= 1'b1;
        in_data  <= d;
        in_first <= first;
        in_ub    <= ub;
        @(posedge clk);
        while (in_full) @(posedge clk);
        items_taken++;
        n = predict_frame(d, first, ub);
        if (typed_n < 0) begin
            for (int k = 0; k < n; k++) add_frame(pred_res[k]);
        end else if (typed_n == 3) begin
            for (int k = 0; k < 3; k++) add_frame(sc_entry(k));
        end else if (typed_n == 1) begin
            add_frame('{d, 1'b0, typed_end, 1'b1});
        end
    endtask

    // waits for the block to go quiet, then writes the length size
    task automatic write_len_size(input logic [LEN_SIZE_W-1:0] v);
        @(negedge clk);
        in_push <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        len_size_p = v;
        size_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_unit();
        logic [7:0]              data_q[$];
        logic [UNIT_BYTES_W-1:0] ub;
        int                      roll;
        int                      n_nal;
        int                      len;
        int                      s;
        int                      n;
        s    = int'(eff_len_size());
        roll = $urandom_range(99, 0);
        ub   = '0;
        if (roll < 80) begin
            n_nal = $urandom_range(4, 1);
            for (int k = 0; k < n_nal; k++) begin
                case ($urandom_range(19, 0))
                    0, 1:    len = 0;
                    2:       len = $urandom_range(40, 7);
                    default: len = $urandom_range(6, 1);
                endcase
                for (int i = s - 1; i >= 0; i--)
                    data_q.insert(data_q.size(), 8'(len >> (8 * i)));
                for (int i = 0; i < len; i++)
                    data_q.insert(data_q.size(), 8'($urandom()));
            end
            // trailing bytes, sometimes too few for a prefix
            if (roll >= 75) begin
                n = $urandom_range(s, 1);
                for (int i = 0; i < n; i++) data_q.insert(data_q.size(), 8'($urandom()));
            end
            ub = UNIT_BYTES_W'(data_q.size());
            // unit count cut short
            if (roll >= 70 && roll < 75) ub = UNIT_BYTES_W'($urandom_range(data_q.size(), 1));
        end else if (roll < 90) begin
            ub = UNIT_BYTES_W'($urandom_range(12, 1));
            for (int i = 0; i < int'(ub); i++) data_q.insert(data_q.size(), 8'($urandom()));
        end else if (roll < 95) begin
            ub = UNIT_BYTES_W'($urandom());
            n  = $urandom_range(8, 3);
            for (int i = 0; i < n; i++) data_q.insert(data_q.size(), 8'($urandom()));
        end else begin
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++) data_q.insert(data_q.size(), 8'($urandom()));
        end
        for (int i = 0; i < data_q.size(); i++)
            send_byte(data_q[i], (i == 0) && (roll < 95), ub, -1, 1'b0);
    endtask

    task automatic report_miss(input t_frame_res want, input t_frame_res got,
                               input logic none_waiting);
        errors++;
        if (errors <= 10) begin
            if (none_waiting)
                $display("unexpected result: byte %02h start %b end %b last %b",
                         got.out_byte, got.nal_start, got.nal_end, got.last_of_run);
            else begin
                $display("mismatch #%0d: exp byte %02h start %b end %b last %b",
                         frames_checked, want.out_byte, want.nal_start, want.nal_end,
                         want.last_of_run);
                $display("    got byte %02h start %b end %b last %b",
                         got.out_byte, got.nal_start, got.nal_end, got.last_of_run);
            end
        end
    endtask

    always @(negedge clk) begin
        out_pop <= rst_n && ($urandom_range(99, 0) >= recv_idle);
    end

    always @(posedge clk) begin
        t_frame_res got;
        t_frame_res want;
        if (rst_n && out_pop && !out_empty) begin
            got = '{out_byte, out_start, out_end, out_last};
            if (expected_frames.size() == 0) begin
                report_miss(got, got, 1'b1);
            end else begin
                want = expected_frames.pop_front();
                if (got !== want) report_miss(want, got, 1'b0);
                frames_checked++;
            end
        end
    end

    initial begin
        int target;
        add_row(byte_row(8'hAA, 1'b0, 24'd0, 0, 1'b0));
        add_row(byte_row(8'h55, 1'b1, 24'd0, 0, 1'b0));
        add_row(byte_row(8'h00, 1'b1, 24'd7, 0, 1'b0));
        add_row(byte_row(8'h00, 1'b0, 24'd0, 0, 1'b0));
        add_row(byte_row(8'h00, 1'b0, 24'd0, 0, 1'b0));
        add_row(byte_row(8'h02, 1'b0, 24'd0, 3, 1'b0));
        add_row(byte_row(8'hFF, 1'b0, 24'd0, 1, 1'b0));
        add_row(byte_row(8'h00, 1'b0, 24'd0, 1, 1'b1));
        add_row(byte_row(8'h5A, 1'b0, 24'd0, 0, 1'b0));
        // length overruns the unit
        add_row(byte_row(8'h00, 1'b1, 24'd5, 0, 1'b0));
        add_row(byte_row(8'h00, 1'b0, 24'd0, 0, 1'b0));
        add_row(byte_row(8'h00, 1'b0, 24'd0, 0, 1'b0));
        add_row(byte_row(8'h05, 1'b0, 24'd0, 0, 1'b0));
        add_row(size_row(LEN_SIZE_MIN));
        // zero-length nal in a unit of the widest count
        add_row(byte_row(8'h00, 1'b1, 24'hFFFFFF, 0, 1'b0));
        add_row(byte_row(8'h01, 1'b0, 24'd0, 3, 1'b0));
        add_row(byte_row(8'hFF, 1'b0, 24'd0, 1, 1'b1));
        // size drops below the prefix bytes already taken
        add_row(size_row(3'd2));
        add_row(byte_row(8'h00, 1'b1, 24'd3, -1, 1'b0));
        add_row(size_row(3'd0));
        add_row(byte_row(8'h01, 1'b0, 24'd0, -1, 1'b0));
        add_row(byte_row(8'h80, 1'b0, 24'd0, -1, 1'b0));
        add_row(size_row(3'd7));
        add_row(byte_row(8'h12, 1'b0, 24'd0, 0, 1'b0));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_SIZE)
                write_len_size(rows[i].size);
            else
                send_byte(rows[i].data, rows[i].first, rows[i].ub,
                          rows[i].exp_n, rows[i].exp_end);
        end

        for (int p = 0; p < 9; p++) begin
            if (p < 3) begin
                send_idle = 14;
                recv_idle = 53;
            end else if (p < 6) begin
                send_idle = 53;
                recv_idle = 14;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_len_size(SIZE_PLAN[p]);
            target = items_taken + ITEMS_PER_STRETCH;
            while (items_taken < target) run_unit();
        end

        @(negedge clk);
        in_push <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d input bytes over %0d length-size writes",
                 items_taken, size_writes);
        $display("%0d framed bytes checked, %0d mismatches or stray results",
                 frames_checked, errors);
        if (errors == 0)
            $display("tb_length_prefixed_nal_to_start_code: clean");
        else
            $display("tb_length_prefixed_nal_to_start_code: errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results still expected", expected_frames.size());
        $display("tb_length_prefixed_nal_to_start_code: errors");
        $finish;
    end

endmodule
